/* rtl/pmst_pkg.sv */
package pmst_pkg;

  // Fixed widths of the result fields
  localparam int TOTAL_BITS = 21;
  localparam int INDEX_OUT_BITS = 5;
  localparam int COST_OUT_BITS = 16;

  typedef logic [1:0] status_t;
  localparam status_t STATUS_OK           = 2'd0;
  localparam status_t STATUS_DISCONNECTED = 2'd1;
  localparam status_t STATUS_OVERFLOW     = 2'd2;

  // Register index (word address bit 2)
  localparam logic REG_VERTEX_COUNT = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOOK_A,
    ST_LOOK_B,
    ST_EDGE,
    ST_WR_XY,
    ST_WR_YX,
    ST_DECIDE,
    ST_SEARCH,
    ST_FIRST,
    ST_PASS,
    ST_STEP,
    ST_OVF,
    ST_CLEAR
  } state_t;

endpackage

/* rtl/prim_minimum_spanning_tree.sv */
// Minimum spanning tree over a loaded edge list (Prim, adjacency matrix).
// Slave stream: one item per edge, tdata = {weight, label_b, label_a},
// tlast marks the final edge of the graph. Master stream: one item per tree
// edge, tdata = {total_cost, edge_cost, tree_to, tree_from}, tuser = status,
// tlast on the final item of the run; a disconnected graph or a label overflow
// ends the run with a status item. vertex_count is set over APB at address 0
// while the block is idle, a rule on the user that the block does not enforce;
// reads return it. For an ordinary edge, each endpoint label is searched one
// table entry a cycle, then, if both labels fit and differ, the edge is written
// twice through the single write port of the adjacency memory. The final edge
// adds the solve: an opening search over n*n entries reading the adjacency
// memory one entry a cycle, then n-1 passes (one memory read per vertex), then
// a clearing sweep of all MAX_VERTICES^2 entries. Reset starts that same sweep;
// no item is taken until it ends. Configuration writes are taken at any time.
// Results sit in an output register; while the receiver stalls, the solve
// holds at the next result and no new edge is taken until the run is done.
module prim_minimum_spanning_tree #(
  parameter int MAX_VERTICES = 32,
  parameter int WEIGHT_BITS  = 16,
  parameter int LABEL_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // label_a[15:0], label_b[31:16], weight[47:32]
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // tree_from[4:0], tree_to[9:5], edge_cost[25:10],
                                 // total_cost[46:26], pad[47]
  output logic [1:0]  m_tuser,   // status[1:0]
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int LB = (LABEL_BITS < 16) ? LABEL_BITS : 16;
  localparam int WB = (WEIGHT_BITS < 16) ? WEIGHT_BITS : 16;
  localparam int IW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
  localparam int AW = $clog2(DEPTH);
  localparam int TB = pmst_pkg::TOTAL_BITS;
  localparam logic [WB:0] ABSENT = {1'b1, {WB{1'b0}}};

  function automatic logic [AW-1:0] adj_addr(input logic [IW-1:0] row,
                                             input logic [IW-1:0] col);
    adj_addr = AW'(row * MAX_VERTICES + col);
  endfunction

  pmst_pkg::state_t state, state_next;

  logic [5:0]    vc;
  logic [CW-1:0] n, nm1;
  logic [6:0]    vc7;

  logic [LB-1:0] la, lb, look_lbl;
  logic [WB-1:0] w;
  logic          last_in;
  logic [CW-1:0] lk_i;
  logic [CW-1:0] label_count;
  logic [LB-1:0] label_tab [MAX_VERTICES];
  logic [IW-1:0] x, y;
  logic          x_ok, y_ok;
  logic          ovf;
  logic          hit, at_end, full;

  logic [WB:0]   adj_mem [DEPTH];
  logic          mem_we, rd_en;
  logic [AW-1:0] mem_wa, rd_addr;
  logic [WB:0]   mem_wd, rd_data;
  logic [AW-1:0] clr;

  logic [IW-1:0] r, c, tag_r, tag_c;
  logic          rv, iss_done, issue, last_issue, pass_done;
  logic [WB:0]   best;
  logic [IW-1:0] ba, bb, pick;
  logic          init_pass;
  logic [WB:0]   near_cost [MAX_VERTICES];
  logic [IW-1:0] near [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] in_tree;
  logic [WB:0]   cbest, nd;
  logic [IW-1:0] cpick, cnear, nn;
  logic          upd;
  logic [CW-1:0] rem;

  logic [TB-1:0] total, total_new;
  logic [TB:0]   sum;
  logic [WB-1:0] add_w;

  logic          out_free, out_load;
  logic [pmst_pkg::INDEX_OUT_BITS-1:0] o_from, o_to;
  logic [pmst_pkg::COST_OUT_BITS-1:0]  o_cost;
  logic [TB-1:0] o_total;
  pmst_pkg::status_t o_status;
  logic          o_last;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == pmst_pkg::REG_VERTEX_COUNT) ? {26'b0, vc} : 32'b0;

  assign vc7 = {1'b0, vc};
  always_comb begin
    if (vc7 < 7'd2) begin
      n = CW'(2);
    end else if (vc7 > 7'(MAX_VERTICES)) begin
      n = CW'(MAX_VERTICES);
    end else begin
      n = CW'(vc7);
    end
  end
  assign nm1 = n - 1'b1;

  // Label search, one entry a cycle
  assign look_lbl = (state == pmst_pkg::ST_LOOK_A) ? la : lb;
  assign hit = (lk_i < label_count) && (label_tab[lk_i[IW-1:0]] == look_lbl);
  assign at_end = (lk_i == label_count);
  assign full = (label_count >= n);

  assign out_free = !m_tvalid || m_tready;

  // Running total, saturating
  assign add_w = (state == pmst_pkg::ST_FIRST) ? best[WB-1:0] : cbest[WB-1:0];
  assign sum = {1'b0, total} + (TB+1)'(add_w);
  assign total_new = sum[TB] ? {TB{1'b1}} : sum[TB-1:0];

  // Relaxation of the vertex whose row entry has just come back
  assign upd = init_pass || (rd_data < near_cost[tag_r]);
  assign nd = upd ? rd_data : near_cost[tag_r];
  assign nn = upd ? pick : near[tag_r];

  assign issue = !iss_done &&
                 (state == pmst_pkg::ST_SEARCH || state == pmst_pkg::ST_PASS);
  assign last_issue = (state == pmst_pkg::ST_SEARCH) ?
                      (CW'(r) == nm1 && CW'(c) == nm1) : (CW'(r) == nm1);
  assign pass_done = iss_done && !rv;

  always_comb begin
    state_next = state;
    s_tready = 1'b0;
    mem_we = 1'b0;
    mem_wa = clr;
    mem_wd = ABSENT;
    rd_en = issue;
    rd_addr = (state == pmst_pkg::ST_SEARCH) ? adj_addr(r, c) : adj_addr(r, pick);
    out_load = 1'b0;
    o_from = '0;
    o_to = '0;
    o_cost = '0;
    o_total = '0;
    o_status = pmst_pkg::STATUS_OK;
    o_last = 1'b0;
    case (state)
      pmst_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) state_next = pmst_pkg::ST_LOOK_A;
      end
      pmst_pkg::ST_LOOK_A: begin
        if (hit || at_end) state_next = pmst_pkg::ST_LOOK_B;
      end
      pmst_pkg::ST_LOOK_B: begin
        if (hit || at_end) state_next = pmst_pkg::ST_EDGE;
      end
      pmst_pkg::ST_EDGE: begin
        if (x_ok && y_ok && x != y) begin
          state_next = pmst_pkg::ST_WR_XY;
        end else begin
          state_next = pmst_pkg::ST_DECIDE;
        end
      end
      pmst_pkg::ST_WR_XY: begin
        mem_we = 1'b1;
        mem_wa = adj_addr(x, y);
        mem_wd = {1'b0, w};
        state_next = pmst_pkg::ST_WR_YX;
      end
      pmst_pkg::ST_WR_YX: begin
        mem_we = 1'b1;
        mem_wa = adj_addr(y, x);
        mem_wd = {1'b0, w};
        state_next = pmst_pkg::ST_DECIDE;
      end
      pmst_pkg::ST_DECIDE: begin
        if (!last_in) begin
          state_next = pmst_pkg::ST_IDLE;
        end else if (ovf) begin
          state_next = pmst_pkg::ST_OVF;
        end else begin
          state_next = pmst_pkg::ST_SEARCH;
        end
      end
      pmst_pkg::ST_SEARCH: begin
        if (pass_done) state_next = pmst_pkg::ST_FIRST;
      end
      pmst_pkg::ST_FIRST: begin
        out_load = out_free;
        if (best[WB]) begin
          o_total = total;
          o_status = pmst_pkg::STATUS_DISCONNECTED;
          o_last = 1'b1;
          if (out_free) state_next = pmst_pkg::ST_CLEAR;
        end else begin
          o_from = pmst_pkg::INDEX_OUT_BITS'(ba);
          o_to = pmst_pkg::INDEX_OUT_BITS'(bb);
          o_cost = pmst_pkg::COST_OUT_BITS'(best[WB-1:0]);
          o_total = total_new;
          o_last = (n == CW'(2));
          if (out_free) begin
            state_next = (n == CW'(2)) ? pmst_pkg::ST_CLEAR : pmst_pkg::ST_PASS;
          end
        end
      end
      pmst_pkg::ST_PASS: begin
        if (pass_done && !init_pass) state_next = pmst_pkg::ST_STEP;
      end
      pmst_pkg::ST_STEP: begin
        out_load = out_free;
        if (cbest[WB]) begin
          o_total = total;
          o_status = pmst_pkg::STATUS_DISCONNECTED;
          o_last = 1'b1;
          if (out_free) state_next = pmst_pkg::ST_CLEAR;
        end else begin
          o_from = pmst_pkg::INDEX_OUT_BITS'(cpick);
          o_to = pmst_pkg::INDEX_OUT_BITS'(cnear);
          o_cost = pmst_pkg::COST_OUT_BITS'(cbest[WB-1:0]);
          o_total = total_new;
          o_last = (rem == CW'(1));
          if (out_free) begin
            state_next = (rem == CW'(1)) ? pmst_pkg::ST_CLEAR : pmst_pkg::ST_PASS;
          end
        end
      end
      pmst_pkg::ST_OVF: begin
        out_load = out_free;
        o_status = pmst_pkg::STATUS_OVERFLOW;
        o_last = 1'b1;
        if (out_free) state_next = pmst_pkg::ST_CLEAR;
      end
      pmst_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        if (clr == AW'(DEPTH - 1)) state_next = pmst_pkg::ST_IDLE;
      end
      default: state_next = pmst_pkg::ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pmst_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Adjacency memory: writes only while loading or clearing, reads only while
  // solving, so no forwarding is needed
  always_ff @(posedge clk) begin
    if (mem_we) adj_mem[mem_wa] <= mem_wd;
    if (rd_en) rd_data <= adj_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 6'd32;
      label_count <= '0;
      ovf <= 1'b0;
      total <= '0;
      clr <= '0;
      rv <= 1'b0;
      iss_done <= 1'b0;
      lk_i <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (psel && penable && pwrite && paddr[2] == pmst_pkg::REG_VERTEX_COUNT) begin
        vc <= pwdata[5:0];
      end

      if (out_load) begin
        m_tvalid <= 1'b1;
        m_tdata <= {1'b0, o_total, o_cost, o_to, o_from};
        m_tuser <= o_status;
        m_tlast <= o_last;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        pmst_pkg::ST_IDLE: begin
          if (s_tvalid) begin
            la <= s_tdata[LB-1:0];
            lb <= s_tdata[16 +: LB];
            w <= s_tdata[32 +: WB];
            last_in <= s_tlast;
            lk_i <= '0;
          end
        end
        pmst_pkg::ST_LOOK_A, pmst_pkg::ST_LOOK_B: begin
          if (hit) begin
            lk_i <= '0;
            if (state == pmst_pkg::ST_LOOK_A) begin
              x <= lk_i[IW-1:0];
              x_ok <= 1'b1;
            end else begin
              y <= lk_i[IW-1:0];
              y_ok <= 1'b1;
            end
          end else if (at_end) begin
            lk_i <= '0;
            if (!full) begin
              label_tab[label_count[IW-1:0]] <= look_lbl;
              label_count <= label_count + 1'b1;
            end
            if (state == pmst_pkg::ST_LOOK_A) begin
              x <= label_count[IW-1:0];
              x_ok <= !full;
            end else begin
              y <= label_count[IW-1:0];
              y_ok <= !full;
            end
          end else begin
            lk_i <= lk_i + 1'b1;
          end
        end
        pmst_pkg::ST_EDGE: begin
          if (!(x_ok && y_ok)) ovf <= 1'b1;
        end
        pmst_pkg::ST_DECIDE: begin
          r <= '0;
          c <= '0;
          iss_done <= 1'b0;
          rv <= 1'b0;
          best <= ABSENT;
          ba <= '0;
          bb <= '0;
        end
        pmst_pkg::ST_SEARCH: begin
          rv <= issue;
          tag_r <= r;
          tag_c <= c;
          if (issue) begin
            if (last_issue) begin
              iss_done <= 1'b1;
            end else if (CW'(c) == nm1) begin
              c <= '0;
              r <= r + 1'b1;
            end else begin
              c <= c + 1'b1;
            end
          end
          // strict compare keeps the first in row-major order
          if (rv && rd_data < best) begin
            best <= rd_data;
            ba <= tag_r;
            bb <= tag_c;
          end
        end
        pmst_pkg::ST_FIRST: begin
          if (out_free && !best[WB]) begin
            total <= total_new;
            in_tree <= (MAX_VERTICES'(1) << ba) | (MAX_VERTICES'(1) << bb);
            pick <= ba;
            init_pass <= 1'b1;
            r <= '0;
            iss_done <= 1'b0;
            rv <= 1'b0;
            rem <= n - CW'(2);
          end
        end
        pmst_pkg::ST_PASS: begin
          rv <= issue;
          tag_r <= r;
          if (issue) begin
            if (last_issue) begin
              iss_done <= 1'b1;
            end else begin
              r <= r + 1'b1;
            end
          end
          if (rv) begin
            near_cost[tag_r] <= nd;
            near[tag_r] <= nn;
            if (!init_pass && !in_tree[tag_r] && nd < cbest) begin
              cbest <= nd;
              cpick <= tag_r;
              cnear <= nn;
            end
          end
          // opening pass seeds every vertex from one end; rerun from the other
          if (pass_done && init_pass) begin
            init_pass <= 1'b0;
            pick <= bb;
            r <= '0;
            iss_done <= 1'b0;
            cbest <= ABSENT;
          end
        end
        pmst_pkg::ST_STEP: begin
          if (out_free && !cbest[WB]) begin
            total <= total_new;
            in_tree[cpick] <= 1'b1;
            if (rem != CW'(1)) begin
              rem <= rem - 1'b1;
              pick <= cpick;
              r <= '0;
              iss_done <= 1'b0;
              cbest <= ABSENT;
            end
          end
        end
        pmst_pkg::ST_CLEAR: begin
          label_count <= '0;
          ovf <= 1'b0;
          total <= '0;
          clr <= (clr == AW'(DEPTH - 1)) ? '0 : clr + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> !mem_we)
    else $error("adjacency read and write in the same cycle");

  a_pick_in_tree: assert property (@(posedge clk) disable iff (rst)
    (state == pmst_pkg::ST_PASS) |-> in_tree[pick])
    else $error("relaxation pass from a vertex outside the tree");

  a_step_fresh: assert property (@(posedge clk) disable iff (rst)
    (state == pmst_pkg::ST_STEP && out_free && !cbest[WB]) |-> !in_tree[cpick])
    else $error("tree vertex chosen again");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast && !m_tready) |=> !s_tready)
    else $error("edge taken while a run is still emitting");
`endif

endmodule
